// ----- hw/rtl/bia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Types, codes and defaults shared by the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int MAP_WORDS_DEF = 128;
    localparam int WORD_BITS_DEF = 32;

    localparam int ID_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [ID_W-1:0] ID_BASE_RST = 16'd300;
    localparam logic [ID_W-1:0] ID_LAST_RST = 16'd4395;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ID_BASE = 1'b0,
        REG_ID_LAST = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic {
        STAT_OK        = 1'b0,
        STAT_EXHAUSTED = 1'b1
    } status_t;

    typedef struct packed {
        opcode_t         opcode;
        logic [ID_W-1:0] release_id;
    } req_item_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        status_t         status;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_GRANT,
        S_DIV,
        S_REM,
        S_FREE
    } state_t;

endpackage

// ----- hw/rtl/bitmap_id_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_unit
// First-free identifier allocator over a used-bit map held in RAM.
// ----------------------------------------------------------------------------
// The used-bit map lives in a MAP_WORDS x WORD_BITS RAM with a registered
// read; a flop per word marks it full. After reset the block sweeps every
// RAM word to zero with req_stall high (config writes are
// taken during the sweep). One request is in flight at a time: an
// allocate steps through full-flag group search, word select and RAM read,
// bit search, write-back and response load, and a release through offset
// divide, remainder and RAM read, and write-back, which is skipped when the
// id is out of range or lies past the end of the map. The read-modify-write
// of the RAM word sets these steps. A response waiting in the output
// register does not block new requests; the next allocate only holds in its
// last cycle until the register frees.
// Releases give no response; exhausted allocates answer granted_id 0.
module bitmap_id_allocator_unit
    import bia_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp_data
);

    localparam int AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int GRP     = 16;
    localparam int GIW     = $clog2(GRP);
    localparam int NGRP    = (MAP_WORDS + GRP - 1) / GRP;
    localparam int CAND_W  = $clog2(65536 + MAP_WORDS * WORD_BITS) + 1;
    localparam int RECIP_W = 33;
    localparam int PROD_W  = ID_W + RECIP_W;
    // ceil(2^32 / WORD_BITS): exact quotient for any 16-bit offset
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << 32) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

    state_t state_reg, state_next;

    logic [ID_W-1:0]      id_base_reg, id_last_reg;
    logic [MAP_WORDS-1:0] word_full_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_data_reg;

    logic                 op_release_reg;
    logic [ID_W-1:0]      off_reg;
    logic                 rel_in_range_reg;
    logic [ID_W-1:0]      q_reg;
    logic [NGRP-1:0]      grp_any_reg;
    logic [GIW-1:0]       grp_low_reg [NGRP];
    logic [AW-1:0]        w_reg;
    logic                 none_reg;
    logic [BW-1:0]        p_reg;
    logic                 found_reg;
    logic [CAND_W-1:0]    wbase_reg;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic                 req_xfer, hold;
    logic [NGRP*GRP-1:0]  wf_pad;
    logic [NGRP-1:0]      grp_any_next;
    logic [GIW-1:0]       grp_low_next [NGRP];
    logic [AW-1:0]        w_next;
    logic                 none_next;
    logic [BW-1:0]        p_scan;
    logic                 found_scan;
    logic [CAND_W-1:0]    cand;
    logic                 grant_ok;
    logic [WORD_BITS-1:0] set_word, clr_word;
    logic [PROD_W-1:0]    prod;
    logic [ID_W-1:0]      rem;
    logic                 rel_hit;

    assign req_xfer  = req_valid && !req_stall;
    assign hold      = rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first level of the free-word search: lowest non-full word per group
    always_comb
    begin
        wf_pad = '1;
        wf_pad[MAP_WORDS-1:0] = word_full_reg;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_low_next[g] = '0;
            for (int k = GRP - 1; k >= 0; k--)
            begin
                if (!wf_pad[g*GRP + k])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_low_next[g] = GIW'(k);
                end
            end
        end
    end

    // second level: lowest group with a free word
    always_comb
    begin
        none_next = 1'b1;
        w_next    = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                none_next = 1'b0;
                w_next    = AW'(g * GRP + int'(grp_low_reg[g]));
            end
        end
    end

    // lowest clear bit of the word just read
    always_comb
    begin
        p_scan     = '0;
        found_scan = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!ram_rdata[i])
            begin
                p_scan     = BW'(i);
                found_scan = 1'b1;
            end
        end
    end

    assign cand     = wbase_reg + CAND_W'(p_reg);
    assign grant_ok = !none_reg && found_reg && (cand <= CAND_W'(id_last_reg));
    assign set_word = ram_rdata | (WORD_BITS'(1) << p_reg);
    assign clr_word = ram_rdata & ~(WORD_BITS'(1) << p_reg);

    assign prod    = PROD_W'(off_reg) * PROD_W'(RECIP);
    assign rem     = off_reg - ID_W'(q_reg * ID_W'(WORD_BITS));
    assign rel_hit = rel_in_range_reg && (32'(q_reg) < 32'(MAP_WORDS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = (req_data.opcode == OP_RELEASE) ? S_DIV : S_FIND;
                end
            end
            S_FIND:  state_next = S_SCAN;
            S_SCAN:  state_next = S_GRANT;
            S_GRANT: state_next = hold ? S_GRANT : S_IDLE;
            S_DIV:   state_next = S_REM;
            S_REM:   state_next = rel_hit ? S_FREE : S_IDLE;
            S_FREE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_stall = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = w_reg;
        ram_wdata = set_word;
        ram_re    = 1'b0;
        ram_raddr = w_next;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_FIND:
            begin
                ram_re = !none_next;
            end
            S_GRANT:
            begin
                ram_we = !hold && grant_ok;
            end
            S_REM:
            begin
                ram_re    = rel_hit;
                ram_raddr = q_reg[AW-1:0];
            end
            S_FREE:
            begin
                ram_we    = 1'b1;
                ram_waddr = q_reg[AW-1:0];
                ram_wdata = clr_word;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_base_reg   <= ID_BASE_RST;
            id_last_reg   <= ID_LAST_RST;
            word_full_reg <= '0;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ID_BASE: id_base_reg <= cfg_wdata;
                    REG_ID_LAST: id_last_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == S_GRANT && !hold)
            begin
                rsp_valid_reg <= 1'b1;
                if (grant_ok && (&set_word))
                begin
                    word_full_reg[w_reg] <= 1'b1;
                end
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == S_FREE)
            begin
                word_full_reg[q_reg[AW-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_release_reg   <= (req_data.opcode == OP_RELEASE);
            off_reg          <= req_data.release_id - id_base_reg;
            rel_in_range_reg <= (req_data.release_id >= id_base_reg) &&
                                (req_data.release_id <= id_last_reg);
            grp_any_reg      <= grp_any_next;
            grp_low_reg      <= grp_low_next;
        end
        if (state_reg == S_FIND)
        begin
            w_reg    <= w_next;
            none_reg <= none_next;
        end
        if (state_reg == S_SCAN)
        begin
            p_reg     <= p_scan;
            found_reg <= found_scan;
            wbase_reg <= CAND_W'(id_base_reg) + CAND_W'(w_reg) * CAND_W'(WORD_BITS);
        end
        if (state_reg == S_DIV)
        begin
            q_reg <= prod[32 +: ID_W];
        end
        if (state_reg == S_REM)
        begin
            p_reg <= rem[BW-1:0];
        end
        if (state_reg == S_GRANT && !hold)
        begin
            if (grant_ok)
            begin
                rsp_data_reg.granted_id <= cand[ID_W-1:0];
                rsp_data_reg.status     <= STAT_OK;
            end
            else
            begin
                rsp_data_reg.granted_id <= '0;
                rsp_data_reg.status     <= STAT_EXHAUSTED;
            end
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |-> state_reg == S_IDLE)
        else $error("request taken outside idle");

    a_ram_one_port : assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("map RAM read and written in the same cycle");

    a_grant_bit_free : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT && grant_ok) |-> !ram_rdata[p_reg])
        else $error("allocation hit a used bit");

    a_kind_path : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND || state_reg == S_GRANT) |-> !op_release_reg)
        else $error("release request on the allocate path");

    a_exhausted_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status == STAT_EXHAUSTED)
            |-> rsp_data_reg.granted_id == '0)
        else $error("exhausted response carries an id");

endmodule

// ----- hw/rtl/bia_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
